FILE: rtl/assert_macros.svh
// Assertion macros shared by the access list check RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset masks the check.
`define SACL_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, reset masks the check.
`define SACL_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/sacl_pkg.sv
// Shared types, codes and sizing helpers for the access list check block.
`timescale 1ns / 1ps

package sacl_pkg;

	localparam int HOST_ENTRIES_DEF = 64;
	localparam int WILD_ENTRIES_DEF = 32;

	localparam int ADDR_W     = 32;
	localparam int SLOT_W     = 6;
	localparam int WUSED_W    = 6;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 6;
	// wide enough for any table depth in range and for wild_used
	localparam int LIM_W      = 11;
	localparam int SLOT_EXT_W = 16;

	typedef enum logic [1:0] {
		FN_CHECK    = 2'd0,
		FN_HOST_WR  = 2'd1,
		FN_WILD_WR  = 2'd2,
		FN_HOST_CLR = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		DEC_NONE = 2'd0,
		DEC_HOST = 2'd1,
		DEC_WILD = 2'd2,
		DEC_OFF  = 2'd3
	} dec_t;

	localparam logic [CFG_IDX_W-1:0] CFG_LIST_EN   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_WILD_USED = 1'b1;

	typedef struct packed {
		logic               list_en;
		logic [WUSED_W-1:0] wild_used;
	} cfg_t;

	typedef struct packed {
		logic wr;
		logic clr;
	} host_ctl_t;

	function automatic int idx_w(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

endpackage

FILE: rtl/sacl_host_mem.sv
// Host entry table: address and grant memory plus per-entry valid flags.
`timescale 1ns / 1ps

module sacl_host_mem #(
	parameter int  HOST_ENTRIES = sacl_pkg::HOST_ENTRIES_DEF,
	localparam int HW           = sacl_pkg::idx_w(HOST_ENTRIES)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  sacl_pkg::host_ctl_t        ctl,
	input  logic [HW-1:0]              wr_idx,
	input  logic [sacl_pkg::ADDR_W-1:0] wr_addr,
	input  logic                       wr_grant,
	input  logic                       wr_valid,
	input  logic [HW-1:0]              rd_idx,
	output logic [sacl_pkg::ADDR_W-1:0] rd_addr,
	output logic                       rd_grant,
	output logic                       rd_valid
);
	import sacl_pkg::*;

	logic [ADDR_W:0]         mem_q [HOST_ENTRIES];
	logic [ADDR_W:0]         rd_q;
	logic [HOST_ENTRIES-1:0] valid_q;
	logic                    rd_valid_q;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem_q[wr_idx] <= {wr_grant, wr_addr};
		end
		rd_q <= mem_q[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (ctl.clr) begin
				valid_q <= '0;
			end else if (ctl.wr) begin
				valid_q[wr_idx] <= wr_valid;
			end
			rd_valid_q <= valid_q[rd_idx];
		end
	end

	assign rd_addr  = rd_q[ADDR_W-1:0];
	assign rd_grant = rd_q[ADDR_W];
	assign rd_valid = rd_valid_q;

endmodule

FILE: rtl/sacl_wild_mem.sv
// Wildcard entry table: pattern, mask and grant memory.
`timescale 1ns / 1ps

module sacl_wild_mem #(
	parameter int  WILD_ENTRIES = sacl_pkg::WILD_ENTRIES_DEF,
	localparam int WW           = sacl_pkg::idx_w(WILD_ENTRIES)
) (
	input  logic                        clk,
	input  logic                        wr,
	input  logic [WW-1:0]               wr_idx,
	input  logic [sacl_pkg::ADDR_W-1:0] wr_pat,
	input  logic [sacl_pkg::ADDR_W-1:0] wr_mask,
	input  logic                        wr_grant,
	input  logic [WW-1:0]               rd_idx,
	output logic [sacl_pkg::ADDR_W-1:0] rd_pat,
	output logic [sacl_pkg::ADDR_W-1:0] rd_mask,
	output logic                        rd_grant
);
	import sacl_pkg::*;

	localparam int EW = 2 * ADDR_W + 1;

	logic [EW-1:0] mem_q [WILD_ENTRIES];
	logic [EW-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_idx] <= {wr_grant, wr_mask, wr_pat};
		end
		rd_q <= mem_q[rd_idx];
	end

	assign rd_pat   = rd_q[ADDR_W-1:0];
	assign rd_mask  = rd_q[2*ADDR_W-1:ADDR_W];
	assign rd_grant = rd_q[EW-1];

endmodule

FILE: rtl/sacl_ctrl.sv
// Sequencer and shared masked compare unit that walks both tables.
`timescale 1ns / 1ps

module sacl_ctrl #(
	parameter int  HOST_ENTRIES = sacl_pkg::HOST_ENTRIES_DEF,
	parameter int  WILD_ENTRIES = sacl_pkg::WILD_ENTRIES_DEF,
	localparam int HW           = sacl_pkg::idx_w(HOST_ENTRIES),
	localparam int WW           = sacl_pkg::idx_w(WILD_ENTRIES)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sacl_pkg::cfg_t              cfg,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  func,
	input  logic [sacl_pkg::ADDR_W-1:0] address,
	input  logic [sacl_pkg::ADDR_W-1:0] wild_bits,
	input  logic                        grant_in,
	input  logic                        entry_valid,
	input  logic [sacl_pkg::SLOT_W-1:0] slot,
	output sacl_pkg::host_ctl_t         host_ctl,
	output logic [HW-1:0]               host_wr_idx,
	output logic [HW-1:0]               host_rd_idx,
	input  logic [sacl_pkg::ADDR_W-1:0] host_addr,
	input  logic                        host_grant,
	input  logic                        host_valid,
	output logic                        wild_wr,
	output logic [WW-1:0]               wild_wr_idx,
	output logic [WW-1:0]               wild_rd_idx,
	input  logic [sacl_pkg::ADDR_W-1:0] wild_pat,
	input  logic [sacl_pkg::ADDR_W-1:0] wild_mask,
	input  logic                        wild_grant,
	output logic [sacl_pkg::ADDR_W-1:0] wr_addr,
	output logic [sacl_pkg::ADDR_W-1:0] wr_mask,
	output logic                        wr_grant,
	output logic                        wr_valid,
	output logic                        strobe,
	output logic                        permit,
	output logic [1:0]                  decided_by,
	output logic                        done_res
);
	import sacl_pkg::*;

	localparam int MAXE = (HOST_ENTRIES > WILD_ENTRIES) ? HOST_ENTRIES : WILD_ENTRIES;
	localparam int CW   = $clog2(MAXE + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_HSCAN,
		ST_WSCAN
	} state_t;

	state_t                state_q;
	func_t                 func_q;
	logic [ADDR_W-1:0]     addr_q;
	logic [ADDR_W-1:0]     mask_q;
	logic                  grant_q;
	logic                  valid_q;
	logic [SLOT_W-1:0]     slot_q;
	logic [CW-1:0]         cnt_q;
	logic                  pend_s1;
	logic                  strobe_q;
	logic                  permit_q;
	dec_t                  dec_q;
	logic                  done_res_q;

	logic [SLOT_EXT_W-1:0] slot_ext;
	logic                  host_in_range;
	logic                  wild_in_range;
	logic [LIM_W-1:0]      wild_lim;
	logic [LIM_W-1:0]      limit;
	logic                  at_end;
	logic                  scan_wild;
	logic [ADDR_W-1:0]     cmp_mask;
	logic [ADDR_W-1:0]     cmp_pat;
	logic                  entry_ok;
	logic                  hit;
	logic                  hit_grant;

	assign slot_ext      = {{(SLOT_EXT_W - SLOT_W){1'b0}}, slot_q};
	assign host_in_range = slot_ext < SLOT_EXT_W'(HOST_ENTRIES);
	assign wild_in_range = slot_ext < SLOT_EXT_W'(WILD_ENTRIES);

	// clamp the programmed count to the table depth
	assign wild_lim = (LIM_W'(cfg.wild_used) > LIM_W'(WILD_ENTRIES)) ?
		LIM_W'(WILD_ENTRIES) : LIM_W'(cfg.wild_used);

	// shared compare: host entries use an empty mask
	always_comb begin
		scan_wild = (state_q == ST_WSCAN);
		cmp_mask  = scan_wild ? wild_mask : '0;
		cmp_pat   = scan_wild ? wild_pat : host_addr;
		entry_ok  = scan_wild ? 1'b1 : host_valid;
		hit_grant = scan_wild ? wild_grant : host_grant;
		hit       = pend_s1 && entry_ok && ((addr_q & ~cmp_mask) == cmp_pat);
		limit     = scan_wild ? wild_lim : LIM_W'(HOST_ENTRIES);
		at_end    = (LIM_W'(cnt_q) == limit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			strobe_q <= 1'b0;
			cnt_q    <= '0;
			pend_s1  <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						func_q  <= func_t'(func);
						addr_q  <= address;
						mask_q  <= wild_bits;
						grant_q <= grant_in;
						valid_q <= entry_valid;
						slot_q  <= slot;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					permit_q   <= 1'b0;
					dec_q      <= DEC_NONE;
					done_res_q <= 1'b0;
					cnt_q      <= '0;
					pend_s1    <= 1'b0;
					state_q    <= ST_IDLE;
					case (func_q)
						FN_CHECK: begin
							if (!cfg.list_en) begin
								permit_q <= 1'b1;
								dec_q    <= DEC_OFF;
								strobe_q <= 1'b1;
							end else begin
								state_q <= ST_HSCAN;
							end
						end
						FN_HOST_WR: begin
							done_res_q <= host_in_range;
							strobe_q   <= 1'b1;
						end
						FN_WILD_WR: begin
							done_res_q <= wild_in_range;
							strobe_q   <= 1'b1;
						end
						FN_HOST_CLR: begin
							done_res_q <= 1'b1;
							strobe_q   <= 1'b1;
						end
						default: begin
							strobe_q <= 1'b1;
						end
					endcase
				end
				ST_HSCAN, ST_WSCAN: begin
					if (hit) begin
						permit_q <= hit_grant;
						dec_q    <= scan_wild ? DEC_WILD : DEC_HOST;
						strobe_q <= 1'b1;
						state_q  <= ST_IDLE;
					end else if (at_end) begin
						cnt_q   <= '0;
						pend_s1 <= 1'b0;
						if (scan_wild) begin
							// nothing matched: default deny
							permit_q <= 1'b0;
							dec_q    <= DEC_NONE;
							strobe_q <= 1'b1;
							state_q  <= ST_IDLE;
						end else begin
							state_q <= ST_WSCAN;
						end
					end else begin
						// advance the read pointer, compare arrives next cycle
						cnt_q   <= CW'(cnt_q + 1'b1);
						pend_s1 <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign host_ctl.wr  = (state_q == ST_EXEC) && (func_q == FN_HOST_WR) && host_in_range;
	assign host_ctl.clr = (state_q == ST_EXEC) && (func_q == FN_HOST_CLR);
	assign wild_wr      = (state_q == ST_EXEC) && (func_q == FN_WILD_WR) && wild_in_range;
	assign host_wr_idx  = slot_ext[HW-1:0];
	assign wild_wr_idx  = slot_ext[WW-1:0];
	assign host_rd_idx  = cnt_q[HW-1:0];
	assign wild_rd_idx  = cnt_q[WW-1:0];
	assign wr_addr      = addr_q;
	assign wr_mask      = mask_q;
	assign wr_grant     = grant_q;
	assign wr_valid     = valid_q;
	assign strobe       = strobe_q;
	assign permit       = permit_q;
	assign decided_by   = dec_q;
	assign done_res     = done_res_q;

	`include "assert_macros.svh"

	`SACL_ASSERT_IMP(a_strobe_idle, strobe_q, state_q == ST_IDLE, "result while sequencer busy")
	`SACL_ASSERT_NXT(a_strobe_single, strobe_q, !strobe_q, "two results in consecutive cycles")
	`SACL_ASSERT_NXT(a_accept_busy, start && !busy, busy && !strobe_q, "accepted request not taken up")
	`SACL_ASSERT_IMP(a_host_from_scan, strobe_q && (dec_q == DEC_HOST), $past(state_q) == ST_HSCAN, "host verdict outside host scan")

endmodule

FILE: rtl/standard_acl_address_check_unit.sv
// Top level of the standard access list address check block.
`timescale 1ns / 1ps

// Usage:
//   Request channel: drive func and its operands with start high; the
//   request is taken at a clock edge where start is high and busy is low.
//   Config channel: cfg_index 0 writes list_enabled, 1 writes wild_used;
//   a write lands when cfg_valid and cfg_ready are both high. cfg_ready
//   follows !busy.
//   Result channel: strobe is high for one cycle with permit, decided_by
//   and done_res. The receiver cannot hold a result off.
// Sequence, from the accepting edge to the strobe cycle:
//   writes, clears and checks with the list disabled: ST_EXEC registers the result.
//   checks: ST_EXEC, then the host walk over all HOST_ENTRIES entries, then
//   the wildcard walk over min(wild_used, WILD_ENTRIES) entries; an
//   earlier hit ends the walk at once. Both tables are read one entry per
//   cycle through one registered memory port each, into one compare unit.
// A new request may be taken in the strobe cycle.
// Reset clears the config registers and every host valid flag at once;
// table contents are left as they are, no clearing pass is needed.
module standard_acl_address_check_unit #(
	parameter int HOST_ENTRIES = sacl_pkg::HOST_ENTRIES_DEF,
	parameter int WILD_ENTRIES = sacl_pkg::WILD_ENTRIES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [1:0]                      func,
	input  logic [sacl_pkg::ADDR_W-1:0]     address,
	input  logic [sacl_pkg::ADDR_W-1:0]     wild_bits,
	input  logic                            grant_in,
	input  logic                            entry_valid,
	input  logic [sacl_pkg::SLOT_W-1:0]     slot,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [sacl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sacl_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                            strobe,
	output logic                            permit,
	output logic [1:0]                      decided_by,
	output logic                            done_res
);
	import sacl_pkg::*;

	localparam int HW = idx_w(HOST_ENTRIES);
	localparam int WW = idx_w(WILD_ENTRIES);

	cfg_t              cfg_q;
	host_ctl_t         host_ctl;
	logic [HW-1:0]     host_wr_idx;
	logic [HW-1:0]     host_rd_idx;
	logic [ADDR_W-1:0] host_addr;
	logic              host_grant;
	logic              host_valid;
	logic              wild_wr;
	logic [WW-1:0]     wild_wr_idx;
	logic [WW-1:0]     wild_rd_idx;
	logic [ADDR_W-1:0] wild_pat;
	logic [ADDR_W-1:0] wild_mask;
	logic              wild_grant;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] wr_mask;
	logic              wr_grant;
	logic              wr_valid;

	assign cfg_ready = !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_LIST_EN:   cfg_q.list_en <= cfg_data[0];
				CFG_WILD_USED: cfg_q.wild_used <= WUSED_W'(cfg_data);
				default: begin
				end
			endcase
		end
	end

	sacl_ctrl #(
		.HOST_ENTRIES(HOST_ENTRIES),
		.WILD_ENTRIES(WILD_ENTRIES)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.start      (start),
		.busy       (busy),
		.func       (func),
		.address    (address),
		.wild_bits  (wild_bits),
		.grant_in   (grant_in),
		.entry_valid(entry_valid),
		.slot       (slot),
		.host_ctl   (host_ctl),
		.host_wr_idx(host_wr_idx),
		.host_rd_idx(host_rd_idx),
		.host_addr  (host_addr),
		.host_grant (host_grant),
		.host_valid (host_valid),
		.wild_wr    (wild_wr),
		.wild_wr_idx(wild_wr_idx),
		.wild_rd_idx(wild_rd_idx),
		.wild_pat   (wild_pat),
		.wild_mask  (wild_mask),
		.wild_grant (wild_grant),
		.wr_addr    (wr_addr),
		.wr_mask    (wr_mask),
		.wr_grant   (wr_grant),
		.wr_valid   (wr_valid),
		.strobe     (strobe),
		.permit     (permit),
		.decided_by (decided_by),
		.done_res   (done_res)
	);

	sacl_host_mem #(
		.HOST_ENTRIES(HOST_ENTRIES)
	) u_host_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (host_ctl),
		.wr_idx  (host_wr_idx),
		.wr_addr (wr_addr),
		.wr_grant(wr_grant),
		.wr_valid(wr_valid),
		.rd_idx  (host_rd_idx),
		.rd_addr (host_addr),
		.rd_grant(host_grant),
		.rd_valid(host_valid)
	);

	sacl_wild_mem #(
		.WILD_ENTRIES(WILD_ENTRIES)
	) u_wild_mem (
		.clk     (clk),
		.wr      (wild_wr),
		.wr_idx  (wild_wr_idx),
		.wr_pat  (wr_addr),
		.wr_mask (wr_mask),
		.wr_grant(wr_grant),
		.rd_idx  (wild_rd_idx),
		.rd_pat  (wild_pat),
		.rd_mask (wild_mask),
		.rd_grant(wild_grant)
	);

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the standard access list address check unit.
`timescale 1ns / 1ps

module tb;
	import sacl_pkg::*;

	localparam int QUIET_LIMIT = 3000;
	localparam int RANDOM_ITEMS = 1650;

	typedef struct packed {
		func_t             func;
		logic [ADDR_W-1:0] address;
		logic [ADDR_W-1:0] wild_bits;
		logic              grant;
		logic              valid;
		logic [SLOT_W-1:0] slot;
	} acl_req_t;

	class acl_verdict_board;
		typedef struct packed {
			logic permit;
			dec_t decided_by;
			logic done;
		} verdict_t;

		logic               list_en;
		logic [WUSED_W-1:0] wild_used;
		logic [ADDR_W-1:0]  host_addr [HOST_ENTRIES_DEF];
		logic               host_grant [HOST_ENTRIES_DEF];
		logic               host_valid [HOST_ENTRIES_DEF];
		logic [ADDR_W-1:0]  wild_pat [WILD_ENTRIES_DEF];
		logic [ADDR_W-1:0]  wild_mask [WILD_ENTRIES_DEF];
		logic               wild_grant [WILD_ENTRIES_DEF];
		verdict_t           verdict_q [$];
		int                 mismatches;

		function new();
			list_en = 1'b0;
			wild_used = '0;
			mismatches = 0;
			for (int i = 0; i < HOST_ENTRIES_DEF; i++) begin
				host_addr[i] = '0;
				host_grant[i] = 1'b0;
				host_valid[i] = 1'b0;
			end
			for (int i = 0; i < WILD_ENTRIES_DEF; i++) begin
				wild_pat[i] = '0;
				wild_mask[i] = '0;
				wild_grant[i] = 1'b0;
			end
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == CFG_LIST_EN) begin
				list_en = data[0];
			end else begin
				wild_used = data[WUSED_W-1:0];
			end
		endfunction

		// Apply one request to the table copy and return the verdict it must produce.
		function verdict_t predict_verdict(acl_req_t r);
			verdict_t v;
			bit found;
			int n;
			v.permit = 1'b0;
			v.decided_by = DEC_NONE;
			v.done = 1'b0;
			found = 1'b0;
			case (r.func)
				FN_CHECK: begin
					if (!list_en) begin
						v.permit = 1'b1;
						v.decided_by = DEC_OFF;
					end else begin
						for (int i = 0; i < HOST_ENTRIES_DEF; i++) begin
							if (!found && host_valid[i] && host_addr[i] == r.address) begin
								found = 1'b1;
								v.permit = host_grant[i];
								v.decided_by = DEC_HOST;
							end
						end
						n = (wild_used > WILD_ENTRIES_DEF) ? WILD_ENTRIES_DEF : int'(wild_used);
						for (int i = 0; i < n; i++) begin
							if (!found && (r.address & ~wild_mask[i]) == wild_pat[i]) begin
								found = 1'b1;
								v.permit = wild_grant[i];
								v.decided_by = DEC_WILD;
							end
						end
					end
				end
				FN_HOST_WR: begin
					if (int'(r.slot) < HOST_ENTRIES_DEF) begin
						host_addr[r.slot] = r.address;
						host_grant[r.slot] = r.grant;
						host_valid[r.slot] = r.valid;
						v.done = 1'b1;
					end
				end
				FN_WILD_WR: begin
					if (int'(r.slot) < WILD_ENTRIES_DEF) begin
						wild_pat[r.slot] = r.address;
						wild_mask[r.slot] = r.wild_bits;
						wild_grant[r.slot] = r.grant;
						v.done = 1'b1;
					end
				end
				default: begin
					for (int i = 0; i < HOST_ENTRIES_DEF; i++) host_valid[i] = 1'b0;
					v.done = 1'b1;
				end
			endcase
			return v;
		endfunction

		function void note_request(acl_req_t r);
			verdict_q.push_back(predict_verdict(r));
		endfunction

		function void check_result(logic p, logic [1:0] d, logic dn);
			verdict_t got;
			verdict_t want;
			got.permit = p;
			got.decided_by = dec_t'(d);
			got.done = dn;
			if (verdict_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result with no request outstanding: permit=%0b decided_by=%0d done=%0b",
						p, d, dn);
			end else begin
				want = verdict_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"verdict mismatch: expected permit=%0b decided_by=%0d done=%0b,",
							" got permit=%0b decided_by=%0d done=%0b"},
							want.permit, want.decided_by, want.done, p, d, dn);
				end
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic [1:0]            func = FN_CHECK;
	logic [ADDR_W-1:0]     address = '0;
	logic [ADDR_W-1:0]     wild_bits = '0;
	logic                  grant_in = 1'b0;
	logic                  entry_valid = 1'b0;
	logic [SLOT_W-1:0]     slot = '0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_LIST_EN;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  strobe;
	logic                  permit;
	logic [1:0]            decided_by;
	logic                  done_res;

	acl_verdict_board board;
	int                idle_pct = 0;
	int                quiet_cycles = 0;
	logic [ADDR_W-1:0] addr_pool [16];
	bit                wild_written [WILD_ENTRIES_DEF];

	standard_acl_address_check_unit dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && strobe) board.check_result(permit, decided_by, done_res);
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Hold start high until the request is taken; leave it high for a back-to-back request.
	task automatic send_request(input acl_req_t r);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		func <= r.func;
		address <= r.address;
		wild_bits <= r.wild_bits;
		grant_in <= r.grant;
		entry_valid <= r.valid;
		slot <= r.slot;
		@(posedge clk);
		while (busy) @(posedge clk);
		board.note_request(r);
		if (r.func == FN_WILD_WR && int'(r.slot) < WILD_ENTRIES_DEF) wild_written[r.slot] = 1'b1;
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (board.verdict_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		start <= 1'b0;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		board.set_register(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic acl_req_t make_request(func_t f, logic [ADDR_W-1:0] a,
			logic [ADDR_W-1:0] b, logic g, logic v, logic [SLOT_W-1:0] s);
		acl_req_t r;
		r.func = f;
		r.address = a;
		r.wild_bits = b;
		r.grant = g;
		r.valid = v;
		r.slot = s;
		return r;
	endfunction

	function automatic logic [ADDR_W-1:0] random_mask();
		int k;
		k = $urandom_range(32);
		case ($urandom_range(3))
			0: random_mask = (k == 32) ? '1 : ((32'h1 << k) - 1);
			1: random_mask = '0;
			2: random_mask = '1;
			default: random_mask = $urandom;
		endcase
	endfunction

	function automatic acl_req_t random_request();
		acl_req_t r;
		int pick;
		int w;
		logic [ADDR_W-1:0] hit;
		r = make_request(FN_CHECK, $urandom, $urandom, 1'($urandom_range(1)),
			1'($urandom_range(1)), 6'($urandom_range(63)));
		pick = $urandom_range(99);
		w = $urandom_range(WILD_ENTRIES_DEF - 1);
		hit = (board.wild_pat[w] & ~board.wild_mask[w]) | (r.address & board.wild_mask[w]);
		if (pick < 48) begin
			// aim the check at a stored host, a wildcard entry, just beside one, or a pooled address
			case ($urandom_range(3))
				0: r.address = board.host_addr[$urandom_range(HOST_ENTRIES_DEF - 1)];
				1: if (wild_written[w]) r.address = hit;
				2: if (wild_written[w]) r.address = hit ^ (32'h1 << $urandom_range(31));
				default: r.address = addr_pool[$urandom_range(15)];
			endcase
		end else if (pick < 73) begin
			r.func = FN_HOST_WR;
			r.valid = ($urandom_range(9) != 0);
			if ($urandom_range(3) != 0) r.address = addr_pool[$urandom_range(15)];
		end else if (pick < 90) begin
			r.func = FN_WILD_WR;
			if ($urandom_range(5) != 0) r.slot = 6'($urandom_range(WILD_ENTRIES_DEF - 1));
			r.wild_bits = random_mask();
			if ($urandom_range(7) != 0) r.address = r.address & ~r.wild_bits;
		end else if (pick < 93) begin
			r.func = FN_HOST_CLR;
		end else begin
			r.func = func_t'($urandom_range(3));
		end
		return r;
	endfunction

	initial begin
		int phase;
		int sent;
		int prefix;
		logic [WUSED_W-1:0] wu;
		logic en;
		logic [ADDR_W-1:0] m;
		board = new();
		phase = 0;
		sent = 0;
		for (int i = 0; i < 16; i++) addr_pool[i] = $urandom;
		addr_pool[0] = '0;
		addr_pool[1] = '1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// list disabled after reset: everything passes
		send_request(make_request(FN_CHECK, 32'h0000_0000, '0, 1'b0, 1'b0, 6'd0));
		send_request(make_request(FN_CHECK, 32'hFFFF_FFFF, '1, 1'b1, 1'b1, 6'd63));
		send_request(make_request(FN_WILD_WR, 32'h0A00_0000, 32'h00FF_FFFF, 1'b1, 1'b0, 6'd0));
		// pattern has a one under its mask: never matches
		send_request(make_request(FN_WILD_WR, 32'hC0A8_0001, 32'h0000_00FF, 1'b0, 1'b1, 6'd1));
		send_request(make_request(FN_WILD_WR, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0, 6'd2));
		send_request(make_request(FN_WILD_WR, 32'h1234_5678, 32'h0000_0000, 1'b1, 1'b1, 6'd32));
		send_request(make_request(FN_WILD_WR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 6'd63));
		send_request(make_request(FN_HOST_WR, 32'hFFFF_FFFF, '0, 1'b1, 1'b1, 6'd0));
		send_request(make_request(FN_HOST_WR, 32'h0A00_0005, '1, 1'b0, 1'b1, 6'd63));
		// duplicate host: the lower slot wins
		send_request(make_request(FN_HOST_WR, 32'h0A00_0005, '0, 1'b1, 1'b1, 6'd5));
		// stored but invalid
		send_request(make_request(FN_HOST_WR, 32'h0102_0304, '0, 1'b0, 1'b0, 6'd6));
		drain_results();
		write_register(CFG_LIST_EN, 6'b111111);
		write_register(CFG_WILD_USED, 6'd3);
		send_request(make_request(FN_CHECK, 32'hFFFF_FFFF, '0, 1'b0, 1'b0, 6'd0));
		send_request(make_request(FN_CHECK, 32'h0A00_0005, '0, 1'b0, 1'b0, 6'd0));
		send_request(make_request(FN_CHECK, 32'h0A12_3456, '0, 1'b0, 1'b0, 6'd0));
		send_request(make_request(FN_CHECK, 32'hC0A8_0001, '0, 1'b0, 1'b0, 6'd0));
		send_request(make_request(FN_CHECK, 32'h0102_0304, '0, 1'b0, 1'b0, 6'd0));
		drain_results();
		write_register(CFG_WILD_USED, 6'd0);
		send_request(make_request(FN_CHECK, 32'h0102_0304, '0, 1'b0, 1'b0, 6'd0));
		send_request(make_request(FN_CHECK, 32'h0000_0000, '0, 1'b0, 1'b0, 6'd0));
		send_request(make_request(FN_HOST_CLR, 32'hFFFF_FFFF, '1, 1'b1, 1'b1, 6'd63));
		send_request(make_request(FN_CHECK, 32'hFFFF_FFFF, '0, 1'b0, 1'b0, 6'd0));
		drain_results();
		write_register(CFG_WILD_USED, 6'd2);
		send_request(make_request(FN_CHECK, 32'h0A00_0005, '0, 1'b0, 1'b0, 6'd0));

		while (sent < RANDOM_ITEMS) begin
			drain_results();
			idle_pct = (phase % 3 == 0) ? 0 : ((phase % 3 == 1) ? 81 : 22);
			if (phase % 5 == 0) begin
				// reload the whole wildcard list in order
				for (int i = 0; i < WILD_ENTRIES_DEF; i++) begin
					m = random_mask();
					send_request(make_request(FN_WILD_WR, $urandom & ~m, m,
						1'($urandom_range(1)), 1'($urandom_range(1)), 6'(i)));
					sent++;
				end
				drain_results();
			end
			prefix = 0;
			while (prefix < WILD_ENTRIES_DEF && wild_written[prefix]) prefix++;
			case (phase)
				1: wu = (prefix == WILD_ENTRIES_DEF) ? 6'd63 : 6'(prefix);
				2: wu = 6'(prefix);
				3: wu = 6'd0;
				default: wu = (prefix == WILD_ENTRIES_DEF) ? 6'($urandom_range(63))
					: 6'($urandom_range(prefix));
			endcase
			en = (phase == 4) ? 1'b0 : ($urandom_range(5) != 0);
			write_register(CFG_WILD_USED, wu);
			write_register(CFG_LIST_EN, {5'($urandom), en});
			repeat ($urandom_range(40, 120)) begin
				send_request(random_request());
				sent++;
			end
			phase++;
		end

		drain_results();
		repeat (120) @(posedge clk);
		if (board.mismatches == 0 && board.verdict_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
